FILE: hdl/phong_fragment_shader_defines.svh
// Assertion macros shared by the Phong fragment shader RTL.
`ifndef PHONG_FRAGMENT_SHADER_DEFINES_SVH
`define PHONG_FRAGMENT_SHADER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PFS_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pfs check failed");
`define PFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pfs check failed");
`else
`define PFS_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define PFS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/pfs_pkg.sv
// Shared constants, register codes and latency helper for the Phong fragment shader.
package pfs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAG_W         = 32;
    localparam int SUM_W         = 64;
    localparam int DIFF_W        = 33;
    localparam int SQRT_STEPS    = 32;
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 32;
    localparam int S_DATA_W      = 192;
    localparam int M_DATA_W      = 32;

    // Light sits at (10,10,10), Q16.16
    localparam logic signed [DIFF_W-1:0] LAMP_COORD = 33'sd655360;

    typedef enum logic [1:0] {
        REG_ALBEDO = 2'd0,
        REG_CAM_X  = 2'd1,
        REG_CAM_Y  = 2'd2,
        REG_CAM_Z  = 2'd3
    } pfs_reg_t;

    // Magnitude, square, sum, root steps, divide steps, sign
    function automatic int unit_latency(input int frac_bits);
        return SQRT_STEPS + frac_bits + 5;
    endfunction

endpackage

FILE: hdl/pfs_unitize.sv
// Pipelined vector normalizer: magnitude, sum of squares, square root and divide.
module pfs_unitize import pfs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [DIFF_W-1:0]   d_x,
    input  logic signed [DIFF_W-1:0]   d_y,
    input  logic signed [DIFF_W-1:0]   d_z,
    output logic signed [FRAC_BITS+1:0] u_x,
    output logic signed [FRAC_BITS+1:0] u_y,
    output logic signed [FRAC_BITS+1:0] u_z
);

    localparam int QW = FRAC_BITS + 1;
    localparam int UW = FRAC_BITS + 2;

    logic signed [DIFF_W-1:0] d [3];
    logic [DIFF_W-1:0]        abs_d [3];
    logic                     big;

    assign d[0] = d_x;
    assign d[1] = d_y;
    assign d[2] = d_z;

    always_comb begin
        big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            abs_d[i] = d[i][DIFF_W-1] ? DIFF_W'(-d[i]) : DIFF_W'(d[i]);
            if (abs_d[i] > {2'b01, {(DIFF_W-2){1'b0}}}) begin
                big = 1'b1;
            end
        end
    end

    // Magnitudes, halved together when one exceeds 2^31
    logic [MAG_W-1:0] mag_a_reg [3];
    logic [2:0]       neg_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_a_reg[i] <= big ? abs_d[i][DIFF_W-1:1] : abs_d[i][MAG_W-1:0];
                neg_a_reg[i] <= d[i][DIFF_W-1];
            end
        end
    end

    // Squares
    logic [SUM_W-1:0] sq_b_reg  [3];
    logic [MAG_W-1:0] mag_b_reg [3];
    logic [2:0]       neg_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_b_reg[i] <= SUM_W'(mag_a_reg[i]) * SUM_W'(mag_a_reg[i]);
            end
            mag_b_reg <= mag_a_reg;
            neg_b_reg <= neg_a_reg;
        end
    end

    // Root: one result bit per stage
    logic [SUM_W-1:0] x_reg    [0:SQRT_STEPS];
    logic [SUM_W-1:0] r_reg    [0:SQRT_STEPS];
    logic [MAG_W-1:0] smag_reg [0:SQRT_STEPS][3];
    logic [2:0]       sneg_reg [0:SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];
            r_reg[0]    <= '0;
            smag_reg[0] <= mag_b_reg;
            sneg_reg[0] <= neg_b_reg;
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 * k);
        logic [SUM_W-1:0] rb;
        assign rb = r_reg[k-1] + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (x_reg[k-1] >= rb) begin
                    x_reg[k] <= x_reg[k-1] - rb;
                    r_reg[k] <= (r_reg[k-1] >> 1) + BIT;
                end else begin
                    x_reg[k] <= x_reg[k-1];
                    r_reg[k] <= r_reg[k-1] >> 1;
                end
                smag_reg[k] <= smag_reg[k-1];
                sneg_reg[k] <= sneg_reg[k-1];
            end
        end
    end

    // Divide: one quotient bit per stage, magnitude never exceeds the length
    logic [MAG_W-1:0] dlen_reg  [0:FRAC_BITS];
    logic             dzero_reg [0:FRAC_BITS];
    logic [MAG_W-1:0] drem_reg  [0:FRAC_BITS][3];
    logic [QW-1:0]    dq_reg    [0:FRAC_BITS][3];
    logic [2:0]       dneg_reg  [0:FRAC_BITS];

    logic [MAG_W-1:0] len0;
    assign len0 = r_reg[SQRT_STEPS][MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                if (smag_reg[SQRT_STEPS][c] >= len0) begin
                    drem_reg[0][c] <= smag_reg[SQRT_STEPS][c] - len0;
                    dq_reg[0][c]   <= QW'(1);
                end else begin
                    drem_reg[0][c] <= smag_reg[SQRT_STEPS][c];
                    dq_reg[0][c]   <= '0;
                end
            end
            dlen_reg[0]  <= len0;
            dzero_reg[0] <= (len0 == '0);
            dneg_reg[0]  <= sneg_reg[SQRT_STEPS];
        end
    end

    for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_div
        logic [MAG_W:0] t    [3];
        logic [MAG_W:0] diff [3];
        logic [2:0]     qb;
        always_comb begin
            for (int c = 0; c < 3; c++) begin
                t[c]    = {drem_reg[j-1][c], 1'b0};
                diff[c] = t[c] - {1'b0, dlen_reg[j-1]};
                qb[c]   = (t[c] >= {1'b0, dlen_reg[j-1]});
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int c = 0; c < 3; c++) begin
                    drem_reg[j][c] <= qb[c] ? diff[c][MAG_W-1:0] : t[c][MAG_W-1:0];
                    dq_reg[j][c]   <= {dq_reg[j-1][c][QW-2:0], qb[c]};
                end
                dlen_reg[j]  <= dlen_reg[j-1];
                dzero_reg[j] <= dzero_reg[j-1];
                dneg_reg[j]  <= dneg_reg[j-1];
            end
        end
    end

    // Apply sign; a zero-length vector gives zero
    logic signed [UW-1:0] u_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                if (dzero_reg[FRAC_BITS]) begin
                    u_reg[c] <= '0;
                end else if (dneg_reg[FRAC_BITS][c]) begin
                    u_reg[c] <= -UW'(dq_reg[FRAC_BITS][c]);
                end else begin
                    u_reg[c] <= UW'(dq_reg[FRAC_BITS][c]);
                end
            end
        end
    end

    assign u_x = u_reg[0];
    assign u_y = u_reg[1];
    assign u_z = u_reg[2];

endmodule

FILE: hdl/phong_fragment_shader.sv
// Phong fragment shader top level: register port, input pipeline, lighting tail and output skid.
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one fragment per item: world position
//   and unnormalized normal, six signed Q16.16 words. Output stream (m_tvalid/m_tready/
//   m_tdata) carries one lit RGBA pixel per item, in order.
//   Configure albedo and camera position over the APB port while the block is idle.
// Timing:
//   One item per clock sustained while m_tready stays high. Latency is set by the
//   32-stage square root and the FRAC_BITS+1-stage divider of the three vector
//   normalizers plus the dot, reflect, power and shade stages.
// Reset:
//   aresetn low clears all valid bits, the skid and the registers (albedo, camera to zero).
// Stall:
//   When the receiver drops m_tready, the waiting pixel moves into a one-entry skid and
//   the pipeline still advances once, so the item in flight is accepted. While the skid
//   is full the whole pipeline holds and s_tready is low; nothing is dropped or repeated.
`include "phong_fragment_shader_defines.svh"
module phong_fragment_shader import pfs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (32 bits each, lowest first)
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // red, green, blue, alpha (8 bits each, lowest first)
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam int QW      = FRAC_BITS + 1;          // clamped scalar, 0..ONE
    localparam int UW      = FRAC_BITS + 2;          // unit vector component
    localparam int RW      = FRAC_BITS + 3;          // reflected component
    localparam int WF      = FRAC_BITS + 3;          // lighting factor
    localparam int PW      = 2 * UW;                 // unit by unit product
    localparam int SW1     = PW + 2;                 // sum of three such products
    localparam int TW      = PW + 1;                 // doubled reflect product
    localparam int PW2     = UW + RW;                // view by reflected product
    localparam int SW2     = PW2 + 2;
    localparam int HW      = 8 + WF - FRAC_BITS;     // shaded value before saturation
    localparam int ONE     = 1 << FRAC_BITS;
    localparam int AMBIENT = ((1 << FRAC_BITS) * 2 + 5) / 10;
    localparam int SPEC_N  = 5;

    localparam logic signed [SW1-1:0] RND1   = SW1'(ONE - 1);
    localparam logic signed [TW-1:0]  RND2   = TW'(ONE - 1);
    localparam logic signed [SW2-1:0] RND3   = SW2'(ONE - 1);
    localparam logic signed [SW2-1:0] ONE_S2 = SW2'(ONE);
    localparam logic signed [UW-1:0]  ONE_U  = UW'(ONE);

    // Stage map: 0 input register, 1..U normalizers, then the lighting tail
    localparam int U        = unit_latency(FRAC_BITS);
    localparam int ST_NL    = U + 2;
    localparam int ST_SPEC0 = U + 6;
    localparam int ST_F     = U + 12;
    localparam int NV       = U + 15;
    localparam int DIFF_D   = ST_F - ST_NL;

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] albedo_reg;
    logic [CFG_DATA_W-1:0] cam_x_reg;
    logic [CFG_DATA_W-1:0] cam_y_reg;
    logic [CFG_DATA_W-1:0] cam_z_reg;
    pfs_reg_t              cfg_sel;

    assign cfg_sel = pfs_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            albedo_reg <= '0;
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_sel)
                REG_ALBEDO: begin
                    albedo_reg <= pwdata;
                end
                REG_CAM_X: begin
                    cam_x_reg <= pwdata;
                end
                REG_CAM_Y: begin
                    cam_y_reg <= pwdata;
                end
                REG_CAM_Z: begin
                    cam_z_reg <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_ALBEDO: prdata = albedo_reg;
            REG_CAM_X:  prdata = cam_x_reg;
            REG_CAM_Y:  prdata = cam_y_reg;
            REG_CAM_Z:  prdata = cam_z_reg;
            default:    prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // The whole pipeline moves together; only a full skid holds it.
    logic                skid_valid_reg;
    logic [M_DATA_W-1:0] skid_data_reg;
    logic [NV-1:0]       vld_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                en;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign m_tvalid = skid_valid_reg || vld_reg[NV-1];
    assign m_tdata  = skid_valid_reg ? skid_data_reg : out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NV-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (vld_reg[NV-1] && !m_tready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Park the stalled pixel while the last stage takes the next one
    always_ff @(posedge aclk) begin
        if (!skid_valid_reg && vld_reg[NV-1] && !m_tready) begin
            skid_data_reg <= out_data_reg;
        end
    end

    // ---------------- input register and direction vectors ----------------
    logic [S_DATA_W-1:0] in_data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            in_data_reg <= s_tdata;
        end
    end

    logic signed [DIFF_W-1:0] pos_e  [3];
    logic signed [DIFF_W-1:0] norm_e [3];
    logic signed [DIFF_W-1:0] cam_e  [3];
    logic signed [DIFF_W-1:0] vd     [3];
    logic signed [DIFF_W-1:0] ld     [3];

    assign cam_e[0] = DIFF_W'(signed'(cam_x_reg));
    assign cam_e[1] = DIFF_W'(signed'(cam_y_reg));
    assign cam_e[2] = DIFF_W'(signed'(cam_z_reg));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_e[i]  = DIFF_W'(signed'(in_data_reg[32*i +: 32]));
            norm_e[i] = DIFF_W'(signed'(in_data_reg[32*(i+3) +: 32]));
            vd[i]     = cam_e[i] - pos_e[i];
            ld[i]     = LAMP_COORD - pos_e[i];
        end
    end

    // ---------------- normalizers ----------------
    logic signed [UW-1:0] n_u [3];
    logic signed [UW-1:0] v_u [3];
    logic signed [UW-1:0] l_u [3];

    pfs_unitize #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .aclk(aclk), .en(en),
        .d_x(norm_e[0]), .d_y(norm_e[1]), .d_z(norm_e[2]),
        .u_x(n_u[0]), .u_y(n_u[1]), .u_z(n_u[2])
    );

    pfs_unitize #(.FRAC_BITS(FRAC_BITS)) u_view (
        .aclk(aclk), .en(en),
        .d_x(vd[0]), .d_y(vd[1]), .d_z(vd[2]),
        .u_x(v_u[0]), .u_y(v_u[1]), .u_z(v_u[2])
    );

    pfs_unitize #(.FRAC_BITS(FRAC_BITS)) u_light (
        .aclk(aclk), .en(en),
        .d_x(ld[0]), .d_y(ld[1]), .d_z(ld[2]),
        .u_x(l_u[0]), .u_y(l_u[1]), .u_z(l_u[2])
    );

    // ---------------- lighting tail ----------------
    logic signed [PW-1:0]  pnl_reg [3];
    logic signed [UW-1:0]  n_p_reg [3];
    logic signed [UW-1:0]  l_p_reg [3];
    logic signed [UW-1:0]  v_p_reg [3];
    logic signed [UW-1:0]  nl_reg;
    logic signed [UW-1:0]  n_q_reg [3];
    logic signed [UW-1:0]  l_q_reg [3];
    logic signed [UW-1:0]  v_q_reg [3];
    logic signed [PW-1:0]  rp_reg  [3];
    logic signed [UW-1:0]  l_r_reg [3];
    logic signed [UW-1:0]  v_r_reg [3];
    logic signed [RW-1:0]  r_reg   [3];
    logic signed [UW-1:0]  v_s_reg [3];
    logic signed [PW2-1:0] pvr_reg [3];
    logic [QW-1:0]         spec_reg [0:SPEC_N];
    logic [QW-1:0]         diff_line_reg [0:DIFF_D-1];
    logic [WF-1:0]         f_reg;
    logic [8+WF-1:0]       shp_reg [3];

    // Dot N.L truncated toward zero, diffuse term
    logic signed [SW1-1:0] nl_sum;
    logic signed [SW1-1:0] nl_adj;
    logic signed [UW-1:0]  nl_val;
    always_comb begin
        nl_sum = SW1'(pnl_reg[0]) + SW1'(pnl_reg[1]) + SW1'(pnl_reg[2]);
        nl_adj = nl_sum + (nl_sum[SW1-1] ? RND1 : SW1'(0));
        nl_val = nl_adj[FRAC_BITS+UW-1:FRAC_BITS];
    end

    // Reflection r = -L + trunc(2 * nl * N / ONE)
    logic signed [TW-1:0] rt    [3];
    logic signed [TW-1:0] rt_adj[3];
    logic signed [RW-1:0] rt_q  [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rt[i]     = {rp_reg[i], 1'b0};
            rt_adj[i] = rt[i] + (rt[i][TW-1] ? RND2 : TW'(0));
            rt_q[i]   = rt_adj[i][FRAC_BITS+RW-1:FRAC_BITS];
        end
    end

    // Specular base V.r, truncated and clamped to 0..ONE
    logic signed [SW2-1:0] vr_sum;
    logic signed [SW2-1:0] vr_adj;
    logic signed [SW2-1:0] vr_sh;
    logic [QW-1:0]         spec_base;
    always_comb begin
        vr_sum = SW2'(pvr_reg[0]) + SW2'(pvr_reg[1]) + SW2'(pvr_reg[2]);
        vr_adj = vr_sum + (vr_sum[SW2-1] ? RND3 : SW2'(0));
        vr_sh  = vr_adj >>> FRAC_BITS;
        if (vr_sh[SW2-1]) begin
            spec_base = '0;
        end else if (vr_sh > ONE_S2) begin
            spec_base = QW'(ONE);
        end else begin
            spec_base = vr_sh[QW-1:0];
        end
    end

    logic [HW-1:0] shade_hi [3];
    logic [7:0]    shade_sat [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            shade_hi[c]  = shp_reg[c][8+WF-1:FRAC_BITS];
            shade_sat[c] = (shade_hi[c] > HW'(255)) ? 8'hFF : shade_hi[c][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // N.L products
            for (int i = 0; i < 3; i++) begin
                pnl_reg[i] <= PW'(n_u[i]) * PW'(l_u[i]);
            end
            n_p_reg <= n_u;
            l_p_reg <= l_u;
            v_p_reg <= v_u;

            // N.L and diffuse
            nl_reg           <= nl_val;
            diff_line_reg[0] <= nl_val[UW-1] ? QW'(0) : nl_val[QW-1:0];
            n_q_reg          <= n_p_reg;
            l_q_reg          <= l_p_reg;
            v_q_reg          <= v_p_reg;

            // nl * N products
            for (int i = 0; i < 3; i++) begin
                rp_reg[i] <= PW'(nl_reg) * PW'(n_q_reg[i]);
            end
            l_r_reg <= l_q_reg;
            v_r_reg <= v_q_reg;

            // reflected vector
            for (int i = 0; i < 3; i++) begin
                r_reg[i] <= rt_q[i] - RW'(l_r_reg[i]);
            end
            v_s_reg <= v_r_reg;

            // V.r products
            for (int i = 0; i < 3; i++) begin
                pvr_reg[i] <= PW2'(v_s_reg[i]) * PW2'(r_reg[i]);
            end

            spec_reg[0] <= spec_base;

            // fifth power of two: square five times, truncate each
            for (int k = 1; k <= SPEC_N; k++) begin
                spec_reg[k] <= QW'(((2*QW)'(spec_reg[k-1]) * (2*QW)'(spec_reg[k-1]))
                                   >> FRAC_BITS);
            end

            for (int k = 1; k < DIFF_D; k++) begin
                diff_line_reg[k] <= diff_line_reg[k-1];
            end

            f_reg <= WF'(AMBIENT) + WF'(diff_line_reg[DIFF_D-1]) + WF'(spec_reg[SPEC_N]);

            for (int c = 0; c < 3; c++) begin
                shp_reg[c] <= (8+WF)'(albedo_reg[8*c +: 8]) * (8+WF)'(f_reg);
            end

            out_data_reg <= {albedo_reg[31:24], shade_sat[2], shade_sat[1], shade_sat[0]};
        end
    end

    // ---------------- checks ----------------
    `PFS_ASSERT_NEXT(a_item_enters, aclk, aresetn, s_tvalid && s_tready, vld_reg[0])
    `PFS_ASSERT_IMPLIES(a_skid_cause, aclk, aresetn, $rose(skid_valid_reg), $past(m_tvalid && !m_tready))
    `PFS_ASSERT_IMPLIES(a_spec_clamped, aclk, aresetn, vld_reg[ST_SPEC0], spec_reg[0] <= QW'(ONE))
    `PFS_ASSERT_IMPLIES(a_unit_bound, aclk, aresetn, vld_reg[U], (n_u[0] <= ONE_U) && (n_u[0] >= -ONE_U))

endmodule
